>>> hdl/key_auto_repeat_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Key auto-repeat scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_AUTO_REPEAT_SCHEDULER_MACROS_SVH
`define KEY_AUTO_REPEAT_SCHEDULER_MACROS_SVH

// same-cycle implication
`define KARS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KARS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kars_pkg.sv
// ----------------------------------------------------------------------------
// Key auto-repeat scheduler package
// Sizes, codes, item types and command structs shared by the block's modules.
// ----------------------------------------------------------------------------
package kars_pkg;

  localparam int unsigned MaxKeys        = 16;
  localparam int unsigned MaxRepeatPairs = 31;
  localparam int unsigned IdxW           = $clog2(MaxKeys);
  localparam int unsigned CntW           = $clog2(MaxKeys + 1);
  localparam int unsigned PairW          = $clog2(MaxRepeatPairs + 1);

  localparam logic [31:0] DefaultInterval = 32'd25;
  localparam logic [31:0] DefaultDelay    = 32'd190;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgDelay    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInterval = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEnable0  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEnable1  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEnable2  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgEnable3  = 3'd5;

  localparam logic [1:0] ReqPress   = 2'd0;
  localparam logic [1:0] ReqRelease = 2'd1;

  localparam logic EvRelease = 1'b0;
  localparam logic EvPress   = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key_code;
    logic [31:0] event_time;
  } req_t;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  out_key_code;
    logic [31:0] out_time;
    logic        is_repeat;
    logic        last_of_run;
  } res_t;

  typedef enum logic [1:0] {
    TblNop,
    TblRotate,
    TblInsert,
    TblRemove
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e         op;
    logic [CntW-1:0] pos;
    logic [7:0]      key;
    logic [31:0]     due;
  } tbl_cmd_t;

  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } emit_cmd_t;

  function automatic res_t mk_res(logic kind, logic [7:0] key, logic [31:0] t, logic rep);
    res_t r;
    r.event_kind   = kind;
    r.out_key_code = key;
    r.out_time     = t;
    r.is_repeat    = rep;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/kars_table.sv
// ----------------------------------------------------------------------------
// Held-key table
// Packed, due-ordered entries with one read port and whole-row shift updates.
// ----------------------------------------------------------------------------
`include "key_auto_repeat_scheduler_macros.svh"

module kars_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kars_pkg::tbl_cmd_t          cmd_i,
  input  logic [kars_pkg::IdxW-1:0]   rd_idx_i,
  output logic [kars_pkg::CntW-1:0]   count_o,
  output logic [7:0]                  rd_key_o,
  output logic [31:0]                 rd_due_o
);
  import kars_pkg::*;

  logic [7:0]      key_q [MaxKeys];
  logic [31:0]     due_q [MaxKeys];
  logic [7:0]      key_d [MaxKeys];
  logic [31:0]     due_d [MaxKeys];
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    logic [CntW-1:0] jv;
    int unsigned     nxt;
    int unsigned     prv;
    for (int unsigned j = 0; j < MaxKeys; j++) begin
      jv       = CntW'(j);
      nxt      = (j + 1 < MaxKeys) ? j + 1 : j;
      prv      = (j > 0) ? j - 1 : 0;
      key_d[j] = key_q[j];
      due_d[j] = due_q[j];
      case (cmd_i.op)
        TblRotate: begin
          if (jv + 1'b1 < cmd_i.pos) begin
            key_d[j] = key_q[nxt];
            due_d[j] = due_q[nxt];
          end else if (jv + 1'b1 == cmd_i.pos) begin
            key_d[j] = cmd_i.key;
            due_d[j] = cmd_i.due;
          end
        end
        TblInsert: begin
          if (jv > cmd_i.pos) begin
            key_d[j] = key_q[prv];
            due_d[j] = due_q[prv];
          end else if (jv == cmd_i.pos) begin
            key_d[j] = cmd_i.key;
            due_d[j] = cmd_i.due;
          end
        end
        TblRemove: begin
          if (jv >= cmd_i.pos) begin
            key_d[j] = key_q[nxt];
            due_d[j] = due_q[nxt];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      TblInsert: count_d = count_q + 1'b1;
      TblRemove: count_d = count_q - 1'b1;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned j = 0; j < MaxKeys; j++) begin
      key_q[j] <= key_d[j];
      due_q[j] <= due_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o  = count_q;
  assign rd_key_o = key_q[rd_idx_i];
  assign rd_due_o = due_q[rd_idx_i];

  `KARS_ASSERT_IMP(a_count_max, 1'b1, count_q <= CntW'(MaxKeys), "table count above capacity")
  `KARS_ASSERT_NXT(a_insert_grow, cmd_i.op == TblInsert, count_q == $past(count_q) + 1'b1, "insert did not grow table")
  `KARS_ASSERT_NXT(a_rotate_keep, cmd_i.op == TblRotate || cmd_i.op == TblNop, $stable(count_q), "count moved without insert or remove")

endmodule

>>> hdl/kars_emit.sv
// ----------------------------------------------------------------------------
// Result emitter
// Holds one item back so the final result of a run can carry last_of_run.
// ----------------------------------------------------------------------------
`include "key_auto_repeat_scheduler_macros.svh"

module kars_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kars_pkg::emit_cmd_t cmd_i,
  output logic                result_valid_o,
  output kars_pkg::res_t      result_o
);
  import kars_pkg::*;

  res_t pend_q, pend_d;
  logic pend_v_q, pend_v_d;
  res_t out_q, out_d;
  logic out_v_q, out_v_d;

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = 1'b0;
    if (cmd_i.push) begin
      out_d    = pend_q;
      out_v_d  = pend_v_q;
      pend_d   = cmd_i.res;
      pend_v_d = 1'b1;
    end else if (cmd_i.flush) begin
      out_d             = pend_q;
      out_d.last_of_run = 1'b1;
      out_v_d           = pend_v_q;
      pend_v_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

  `KARS_ASSERT_NXT(a_flush_clears, cmd_i.flush && !cmd_i.push, !pend_v_q, "held item survived flush")
  `KARS_ASSERT_IMP(a_out_source, out_v_q, $past(cmd_i.push || cmd_i.flush), "result without push or flush")

endmodule

>>> hdl/kars_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks the table with one shared due-time comparator and one shared adder.
// ----------------------------------------------------------------------------
module kars_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  kars_pkg::req_t            req_i,
  output logic                      busy_o,
  input  logic [31:0]               delay_i,
  input  logic [31:0]               interval_i,
  input  logic [3:0][63:0]          enable_i,
  output kars_pkg::tbl_cmd_t        tbl_cmd_o,
  output logic [kars_pkg::IdxW-1:0] rd_idx_o,
  input  logic [kars_pkg::CntW-1:0] count_i,
  input  logic [7:0]                rd_key_i,
  input  logic [31:0]               rd_due_i,
  output kars_pkg::emit_cmd_t       emit_o
);
  import kars_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StCheck   = 3'd1;
  localparam logic [2:0] StRepPress = 3'd2;
  localparam logic [2:0] StScan    = 3'd3;
  localparam logic [2:0] StFind    = 3'd4;
  localparam logic [2:0] StPass    = 3'd5;
  localparam logic [2:0] StFlush   = 3'd6;

  logic [2:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [PairW-1:0] pairs_q, pairs_d;
  logic [7:0]       rep_key_q, rep_key_d;
  logic [31:0]      rep_due_q, rep_due_d;
  logic [31:0]      due_q, due_d;
  logic             rot_q, rot_d;

  logic        is_press, is_rel, key_en, gt;
  logic [31:0] cmp_b, add_a, add_b, sum;

  assign is_press = req_q.req_type == ReqPress;
  assign is_rel   = req_q.req_type == ReqRelease;
  assign key_en   = enable_i[req_q.key_code[7:6]][req_q.key_code[5:0]];

  assign rd_idx_o = (state_q == StCheck) ? '0 : idx_q[IdxW-1:0];
  assign cmp_b    = (state_q == StCheck) ? req_q.event_time : due_q;
  assign gt       = rd_due_i > cmp_b;
  assign add_a    = (state_q == StRepPress) ? rep_due_q : req_q.event_time;
  assign add_b    = (state_q == StRepPress) ? interval_i : delay_i;
  assign sum      = add_a + add_b;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    idx_d         = idx_q;
    pairs_d       = pairs_q;
    rep_key_d     = rep_key_q;
    rep_due_d     = rep_due_q;
    due_d         = due_q;
    rot_d         = rot_q;
    tbl_cmd_o.op  = TblNop;
    tbl_cmd_o.pos = idx_q;
    tbl_cmd_o.key = rot_q ? rep_key_q : req_q.key_code;
    tbl_cmd_o.due = due_q;
    emit_o.push   = 1'b0;
    emit_o.flush  = 1'b0;
    emit_o.res    = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d   = req_i;
          pairs_d = '0;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (pairs_q < PairW'(MaxRepeatPairs) && count_i != '0 && !gt) begin
          emit_o.push = 1'b1;
          emit_o.res  = mk_res(EvRelease, rd_key_i, rd_due_i, 1'b1);
          rep_key_d   = rd_key_i;
          rep_due_d   = rd_due_i;
          state_d     = StRepPress;
        end else if ((is_press || is_rel) && key_en) begin
          idx_d   = '0;
          state_d = StFind;
        end else if (is_press || is_rel) begin
          state_d = StPass;
        end else begin
          state_d = StFlush;
        end
      end
      StRepPress: begin
        emit_o.push = 1'b1;
        emit_o.res  = mk_res(EvPress, rep_key_q, rep_due_q, 1'b1);
        due_d       = sum;
        idx_d       = CntW'(1);
        rot_d       = 1'b1;
        pairs_d     = pairs_q + 1'b1;
        state_d     = StScan;
      end
      StScan: begin
        if (idx_q == count_i || gt) begin
          tbl_cmd_o.op = rot_q ? TblRotate : TblInsert;
          state_d      = rot_q ? StCheck : StPass;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StFind: begin
        if (idx_q == count_i) begin
          if (is_press && count_i < CntW'(MaxKeys)) begin
            due_d   = sum;
            idx_d   = '0;
            rot_d   = 1'b0;
            state_d = StScan;
          end else begin
            state_d = StPass;
          end
        end else if (rd_key_i == req_q.key_code) begin
          if (is_rel) begin
            tbl_cmd_o.op = TblRemove;
          end
          state_d = StPass;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StPass: begin
        emit_o.push = 1'b1;
        emit_o.res  = mk_res(is_press ? EvPress : EvRelease, req_q.key_code,
                             req_q.event_time, 1'b0);
        state_d     = StFlush;
      end
      StFlush: begin
        emit_o.flush = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      pairs_q <= '0;
      rot_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pairs_q <= pairs_d;
      rot_q   <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rep_key_q <= rep_key_d;
    rep_due_q <= rep_due_d;
    due_q     <= due_d;
  end

  assign busy_o = state_q != StIdle;

endmodule

>>> hdl/key_auto_repeat_scheduler.sv
// ----------------------------------------------------------------------------
// Key auto-repeat scheduler
// Typematic repeat for held keys: a due-ordered table of up to 16 keys, one
// repeat pair (release, press) per due entry, then press/release pass-through.
// ----------------------------------------------------------------------------
// Results leave one per cycle on result_valid_o with no backpressure; the
// receiver must take every item in the cycle it appears. An item occupies
// the block from the start edge until busy drops: a head check and a flush
// for a time advance with nothing due, plus a release, a press and a table
// walk on the shared due-time comparator for each repeat pair (at most 31
// pairs), plus a key search for a press or release and an insert walk for
// a new press, and a pass-through. Results trail the issue by one item
// so the last one of a run is marked; the final result appears after busy
// drops. Configuration writes are always ready.
module key_auto_repeat_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  kars_pkg::req_t                 req_i,
  output logic                           result_valid_o,
  output kars_pkg::res_t                 result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kars_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);
  import kars_pkg::*;

  logic [15:0]      delay_q;
  logic [15:0]      interval_q;
  logic [3:0][63:0] enable_q;
  logic [31:0]      delay_eff, interval_eff;

  tbl_cmd_t        tbl_cmd;
  emit_cmd_t       emit_cmd;
  logic [IdxW-1:0] rd_idx;
  logic [CntW-1:0] count;
  logic [7:0]      rd_key;
  logic [31:0]     rd_due;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= '0;
      interval_q <= '0;
      enable_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDelay:    delay_q     <= cfg_data_i[15:0];
        CfgInterval: interval_q  <= cfg_data_i[15:0];
        CfgEnable0:  enable_q[0] <= cfg_data_i;
        CfgEnable1:  enable_q[1] <= cfg_data_i;
        CfgEnable2:  enable_q[2] <= cfg_data_i;
        CfgEnable3:  enable_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign delay_eff    = (delay_q == '0) ? DefaultDelay : {16'd0, delay_q};
  assign interval_eff = (interval_q == '0) ? DefaultInterval : {16'd0, interval_q};

  kars_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req_i),
    .busy_o     (busy),
    .delay_i    (delay_eff),
    .interval_i (interval_eff),
    .enable_i   (enable_q),
    .tbl_cmd_o  (tbl_cmd),
    .rd_idx_o   (rd_idx),
    .count_i    (count),
    .rd_key_i   (rd_key),
    .rd_due_i   (rd_due),
    .emit_o     (emit_cmd)
  );

  kars_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tbl_cmd),
    .rd_idx_i (rd_idx),
    .count_o  (count),
    .rd_key_o (rd_key),
    .rd_due_o (rd_due)
  );

  kars_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (emit_cmd),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
